@@ hdl/mbcd_pkg.sv @@
// ----------------------------------------------------------------------------
// mbcd_pkg
// Types, codes and arithmetic helpers shared by the change detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mbcd_pkg;

	localparam int COORD_W     = 7;
	localparam int COLOR_W     = 8;
	localparam int BOUND_W     = 8;
	localparam int PIX_THR_W   = 10;
	localparam int SUM_W       = 10;
	localparam int COUNT_W     = 15;
	localparam int CFG_DATA_W  = 15;
	localparam int CFG_INDEX_W = 1;

	localparam int OP_DEPTH  = 4;
	localparam int RES_DEPTH = 2;

	localparam logic [PIX_THR_W-1:0] PIXEL_THR_RESET = 10'd48;
	localparam logic [COUNT_W-1:0]   PATCH_THR_RESET = 15'd16;
	localparam logic [COUNT_W-1:0]   COUNT_MAX       = 15'h7fff;

	localparam int                 BLEND_SHIFT = 2;
	localparam logic [COLOR_W-1:0] BLEND_MUL   = 8'd3;

	typedef enum logic [1:0] {
		KIND_CLEAR   = 2'd0,
		KIND_ADD     = 2'd1,
		KIND_COMPARE = 2'd2,
		KIND_UPDATE  = 2'd3
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PIXEL_THR = 1'd0,
		REG_PATCH_THR = 1'd1
	} cfg_index_t;

	typedef struct packed {
		logic [BOUND_W-1:0] left;
		logic [BOUND_W-1:0] right;
		logic [BOUND_W-1:0] top;
		logic [BOUND_W-1:0] bottom;
	} box_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} rgb_t;

	// One pixel operation handed from the front to the back.
	typedef struct packed {
		logic               is_update;
		logic               in_image;
		logic               patch_end;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		rgb_t               px;
	} op_t;

	typedef struct packed {
		logic [COUNT_W-1:0] changed_count;
		logic               patch_active;
	} res_t;

	function automatic logic [COLOR_W-1:0] absdiff(input logic [COLOR_W-1:0] a,
		input logic [COLOR_W-1:0] b);
		absdiff = (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [SUM_W-1:0] rgb_diff_sum(input rgb_t a, input rgb_t b);
		rgb_diff_sum = SUM_W'(absdiff(a.red, b.red)) + SUM_W'(absdiff(a.green, b.green))
			+ SUM_W'(absdiff(a.blue, b.blue));
	endfunction

	// Running average: three quarters background plus one quarter pixel.
	function automatic logic [COLOR_W-1:0] blend(input logic [COLOR_W-1:0] bg,
		input logic [COLOR_W-1:0] p);
		blend = ((bg >> BLEND_SHIFT) * BLEND_MUL) + (p >> BLEND_SHIFT);
	endfunction

	function automatic rgb_t blend_rgb(input rgb_t bg, input rgb_t p);
		blend_rgb.red   = blend(bg.red, p.red);
		blend_rgb.green = blend(bg.green, p.green);
		blend_rgb.blue  = blend(bg.blue, p.blue);
	endfunction

endpackage

`default_nettype wire

@@ hdl/mbcd_ram.sv @@
// ----------------------------------------------------------------------------
// mbcd_ram
// Simple dual-port RAM, one write and one registered read port, read-old.
// ----------------------------------------------------------------------------
`default_nettype none

module mbcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/mbcd_fifo.sv @@
// ----------------------------------------------------------------------------
// mbcd_fifo
// Small register queue; head entry shown while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module mbcd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] dout,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

@@ hdl/mbcd_front.sv @@
// ----------------------------------------------------------------------------
// mbcd_front
// Accept items, keep the box list, mask update pixels, queue pixel work.
// ----------------------------------------------------------------------------
`default_nettype none

module mbcd_front #(
	parameter int IMG_WIDTH  = 128,
	parameter int IMG_HEIGHT = 128,
	parameter int MAX_BOXES  = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic                              busy,
	input  wire logic                              op_full,
	input  wire logic [1:0]                        kind,
	input  wire logic [mbcd_pkg::COORD_W-1:0]      row,
	input  wire logic [mbcd_pkg::COORD_W-1:0]      col,
	input  wire mbcd_pkg::rgb_t                    px,
	input  wire mbcd_pkg::box_t                    box,
	input  wire logic                              patch_end,
	output logic                                   op_push,
	output mbcd_pkg::op_t                          op
);

	localparam int CNT_W = $clog2(MAX_BOXES + 1);

	mbcd_pkg::box_t          boxes_q [MAX_BOXES];
	logic [CNT_W-1:0]        box_count_q;
	logic [MAX_BOXES-1:0]    hit;
	logic                    accept;
	logic                    in_image;
	logic                    masked;
	mbcd_pkg::kind_t         kind_c;

	assign kind_c   = mbcd_pkg::kind_t'(kind);
	assign full     = busy || op_full;
	assign accept   = push && !full;
	assign in_image = (int'(row) < IMG_HEIGHT) && (int'(col) < IMG_WIDTH);

	// Parallel box test against every live entry.
	always_comb begin
		for (int k = 0; k < MAX_BOXES; k++) begin
			hit[k] = (CNT_W'(k) < box_count_q)
				&& ({1'b0, col} >= boxes_q[k].left) && ({1'b0, col} < boxes_q[k].right)
				&& ({1'b0, row} >= boxes_q[k].top) && ({1'b0, row} < boxes_q[k].bottom);
		end
	end
	assign masked = |hit;

	always_comb begin
		op.is_update = (kind_c == mbcd_pkg::KIND_UPDATE);
		op.in_image  = in_image;
		op.patch_end = patch_end;
		op.row       = row;
		op.col       = col;
		op.px        = px;
		case (kind_c)
			mbcd_pkg::KIND_COMPARE: op_push = accept && (in_image || patch_end);
			mbcd_pkg::KIND_UPDATE:  op_push = accept && in_image && !masked;
			default:                op_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_count_q <= '0;
		end else if (accept) begin
			if (kind_c == mbcd_pkg::KIND_CLEAR) begin
				box_count_q <= '0;
			end else if (kind_c == mbcd_pkg::KIND_ADD && box_count_q < CNT_W'(MAX_BOXES)) begin
				box_count_q <= box_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_BOXES; k++) begin
			if (accept && kind_c == mbcd_pkg::KIND_ADD && box_count_q == CNT_W'(k)) begin
				boxes_q[k] <= box;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/mbcd_back.sv @@
// ----------------------------------------------------------------------------
// mbcd_back
// Background store, pixel compare and blend, changed pixel counter.
// ----------------------------------------------------------------------------
`default_nettype none

module mbcd_back #(
	parameter int IMG_WIDTH  = 128,
	parameter int IMG_HEIGHT = 128
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	output logic                                    busy,
	input  wire mbcd_pkg::op_t                      op_head,
	input  wire logic                               op_empty,
	output logic                                    op_pop,
	input  wire logic [mbcd_pkg::PIX_THR_W-1:0]     pix_thr,
	input  wire logic [mbcd_pkg::COUNT_W-1:0]       cnt_thr,
	input  wire logic                               res_full,
	output logic                                    res_push,
	output mbcd_pkg::res_t                          res
);

	localparam int DEPTH  = IMG_WIDTH * IMG_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int RGB_W  = $bits(mbcd_pkg::rgb_t);

	// clearing pass
	logic                           clearing_q;
	logic [ADDR_W-1:0]              clr_addr_q;
	// stage 1
	logic                           valid_s1;
	mbcd_pkg::op_t                  op_s1;
	logic [ADDR_W-1:0]              addr_s1;
	// write issued at the edge the stage 1 op was read
	logic                           rec_valid_q;
	logic [ADDR_W-1:0]              rec_addr_q;
	mbcd_pkg::rgb_t                 rec_data_q;
	logic [mbcd_pkg::COUNT_W-1:0]   cnt_q;

	logic [ADDR_W-1:0]              head_addr;
	logic [RGB_W-1:0]               ram_rdata;
	mbcd_pkg::rgb_t                 bg;
	mbcd_pkg::rgb_t                 new_bg;
	logic [mbcd_pkg::SUM_W-1:0]     sum;
	logic                           changed;
	logic [mbcd_pkg::COUNT_W-1:0]   cnt_next;
	logic                           need_result;
	logic                           go;
	logic                           adv;
	logic                           upd_we;
	logic                           ram_we;
	logic [ADDR_W-1:0]              ram_waddr;
	logic [RGB_W-1:0]               ram_wdata;

	assign busy      = clearing_q;
	assign head_addr = ADDR_W'(int'(op_head.row) * IMG_WIDTH + int'(op_head.col));

	// Bypass the write that landed at the same edge as this op's read.
	assign bg = (rec_valid_q && rec_addr_q == addr_s1) ? rec_data_q
		: mbcd_pkg::rgb_t'(ram_rdata);

	assign sum      = mbcd_pkg::rgb_diff_sum(op_s1.px, bg);
	assign changed  = op_s1.in_image && (sum > mbcd_pkg::SUM_W'(pix_thr));
	assign cnt_next = (changed && cnt_q != mbcd_pkg::COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
	assign new_bg   = mbcd_pkg::blend_rgb(bg, op_s1.px);

	assign need_result = !op_s1.is_update && op_s1.patch_end;
	assign go          = valid_s1 && (!need_result || !res_full);
	assign adv         = !valid_s1 || go;
	assign op_pop      = adv && !op_empty && !clearing_q;
	assign upd_we      = go && op_s1.is_update;

	assign res_push            = go && need_result;
	assign res.changed_count   = cnt_next;
	assign res.patch_active    = (cnt_next > cnt_thr);

	assign ram_we    = clearing_q || upd_we;
	assign ram_waddr = clearing_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clearing_q ? '0 : RGB_W'(new_bg);

	mbcd_ram #(
		.WIDTH(RGB_W),
		.DEPTH(DEPTH)
	) u_bg_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (op_pop),
		.raddr(head_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			valid_s1    <= 1'b0;
			rec_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// sweep zeros through the store, one entry a cycle
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (adv) begin
				valid_s1    <= op_pop;
				rec_valid_q <= upd_we;
			end
			if (go && !op_s1.is_update) begin
				cnt_q <= op_s1.patch_end ? '0 : cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1      <= op_head;
			addr_s1    <= head_addr;
			rec_addr_q <= addr_s1;
			rec_data_q <= new_bg;
		end
	end

	a_no_read_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !op_pop)
		else $error("background read during clearing pass");

	a_no_update_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s1)
		else $error("pixel op in flight during clearing pass");

	a_result_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_count_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !go) |=> $stable(cnt_q))
		else $error("changed counter moved while stage stalled");

endmodule

`default_nettype wire

@@ hdl/masked_background_change_detector.sv @@
// ----------------------------------------------------------------------------
// masked_background_change_detector
// Output: a compare beat that ends a patch shows its result after the op queue,
//   the background read and compare, and the result queue; other beats give none.
// Throughput: one item per cycle unless full; background RAM has one read port.
// Reset: thresholds load 48 and 16, box list and counter clear, then full stays
//   high while the store zeroes IMG_WIDTH*IMG_HEIGHT entries (16384 by default).
// ----------------------------------------------------------------------------
`default_nettype none

module masked_background_change_detector #(
	parameter int IMG_WIDTH  = 128,
	parameter int IMG_HEIGHT = 128,
	parameter int MAX_BOXES  = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// input queue side
	input  wire logic                                 push,
	output logic                                      full,
	input  wire logic [1:0]                           kind,
	input  wire logic [mbcd_pkg::COORD_W-1:0]         row,
	input  wire logic [mbcd_pkg::COORD_W-1:0]         col,
	input  wire logic [mbcd_pkg::COLOR_W-1:0]         red,
	input  wire logic [mbcd_pkg::COLOR_W-1:0]         green,
	input  wire logic [mbcd_pkg::COLOR_W-1:0]         blue,
	input  wire logic [mbcd_pkg::BOUND_W-1:0]         box_left,
	input  wire logic [mbcd_pkg::BOUND_W-1:0]         box_right,
	input  wire logic [mbcd_pkg::BOUND_W-1:0]         box_top,
	input  wire logic [mbcd_pkg::BOUND_W-1:0]         box_bottom,
	input  wire logic                                 patch_end,
	// result queue side
	output logic                                      empty,
	input  wire logic                                 pop,
	output logic      [mbcd_pkg::COUNT_W-1:0]         changed_count,
	output logic                                      patch_active,
	// configuration
	input  wire logic                                 cfg_write,
	input  wire logic [mbcd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [mbcd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int OP_W  = $bits(mbcd_pkg::op_t);
	localparam int RES_W = $bits(mbcd_pkg::res_t);

	logic [mbcd_pkg::PIX_THR_W-1:0] pix_thr_q;
	logic [mbcd_pkg::COUNT_W-1:0]   cnt_thr_q;

	mbcd_pkg::rgb_t  px;
	mbcd_pkg::box_t  box;
	mbcd_pkg::op_t   op_in;
	mbcd_pkg::op_t   op_head;
	mbcd_pkg::res_t  res_in;
	mbcd_pkg::res_t  res_head;
	logic [OP_W-1:0]  op_head_bits;
	logic [RES_W-1:0] res_head_bits;
	logic            op_push;
	logic            op_full;
	logic            op_empty;
	logic            op_pop;
	logic            busy;
	logic            res_push;
	logic            res_full;

	assign px.red     = red;
	assign px.green   = green;
	assign px.blue    = blue;
	assign box.left   = box_left;
	assign box.right  = box_right;
	assign box.top    = box_top;
	assign box.bottom = box_bottom;

	// Thresholds; the user writes them only while the block is idle (not enforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_thr_q <= mbcd_pkg::PIXEL_THR_RESET;
			cnt_thr_q <= mbcd_pkg::PATCH_THR_RESET;
		end else if (cfg_write) begin
			case (mbcd_pkg::cfg_index_t'(cfg_index))
				mbcd_pkg::REG_PIXEL_THR: pix_thr_q <= cfg_data[mbcd_pkg::PIX_THR_W-1:0];
				mbcd_pkg::REG_PATCH_THR: cnt_thr_q <= cfg_data[mbcd_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: take every beat while not full, apply box items at once, queue only
	// pixel work that can touch the store or finish a patch.
	mbcd_front #(
		.IMG_WIDTH (IMG_WIDTH),
		.IMG_HEIGHT(IMG_HEIGHT),
		.MAX_BOXES (MAX_BOXES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.busy     (busy),
		.op_full  (op_full),
		.kind     (kind),
		.row      (row),
		.col      (col),
		.px       (px),
		.box      (box),
		.patch_end(patch_end),
		.op_push  (op_push),
		.op       (op_in)
	);

	// Decouple front and back so either can stall alone.
	mbcd_fifo #(
		.WIDTH(OP_W),
		.DEPTH(mbcd_pkg::OP_DEPTH)
	) u_op_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (op_push),
		.din   (OP_W'(op_in)),
		.full  (op_full),
		.pop   (op_pop),
		.dout  (op_head_bits),
		.empty (op_empty)
	);

	assign op_head = mbcd_pkg::op_t'(op_head_bits);

	// Back: read background, compare or blend, count, emit patch results.
	mbcd_back #(
		.IMG_WIDTH (IMG_WIDTH),
		.IMG_HEIGHT(IMG_HEIGHT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.busy    (busy),
		.op_head (op_head),
		.op_empty(op_empty),
		.op_pop  (op_pop),
		.pix_thr (pix_thr_q),
		.cnt_thr (cnt_thr_q),
		.res_full(res_full),
		.res_push(res_push),
		.res     (res_in)
	);

	// Hold finished results until the consumer pops them.
	mbcd_fifo #(
		.WIDTH(RES_W),
		.DEPTH(mbcd_pkg::RES_DEPTH)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (RES_W'(res_in)),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_head_bits),
		.empty (empty)
	);

	assign res_head      = mbcd_pkg::res_t'(res_head_bits);
	assign changed_count = res_head.changed_count;
	assign patch_active  = res_head.patch_active;

endmodule

`default_nettype wire
